@@ hw/rtl/imm_pkg.sv @@
package imm_pkg;

  // Opcodes of the request channel
  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 5'd16;

  // Result width
  localparam int unsigned OUT_W = 36;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [15:0] element_value;
  } req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] product_value;
    logic                    index_error;
  } rsp_t;

endpackage

@@ hw/rtl/integer_matrix_multiply_core.sv @@
// Integer matrix multiply core.
// Request channel (req_valid / req_stall / req): a request is taken when
// req_valid is high and req_stall is low. Load requests write one element
// of A or B at (row_index, col_index) and give no response; a load outside
// the store is dropped. A read request returns one response on the rsp
// channel: the dot product of row row_index of A and column col_index of B
// over the first inner_dim terms (at most MAX_DIM), or 0 with index_error
// set when the row or column lies outside rows_a / cols_b.
// Sequence: a read steps the inner index k over the inner dimension, one
// multiply-accumulate per cycle, set by the single read port of each
// element memory, through the memory read, multiply and accumulate
// stages; after the drain the result goes to the output register. An
// index error read goes straight to the result. The result sits in an
// output register, so the next request is taken while a response waits;
// a read that finishes while rsp_stall holds the previous response waits
// until that register frees. Loads are taken whenever the core is idle.
// Reset: dimensions return to 16, no response is pending. The element
// memories are not cleared; each element must be loaded before use.
// Configuration (cfg_valid / cfg_ready) is to be written by the user only
// while the core is idle; the core itself does not enforce this.
module integer_matrix_multiply_core #(
  parameter int MAX_DIM    = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  imm_pkg::req_t                    req,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output imm_pkg::rsp_t                    rsp,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [imm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [imm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = ($clog2(MAX_DIM + 1) > 5) ? $clog2(MAX_DIM + 1) : 5;
  localparam int EW    = ELEM_WIDTH;
  localparam int XW    = (EW > 16) ? EW : 16;
  localparam int PW    = (2 * EW > imm_pkg::OUT_W) ? 2 * EW : imm_pkg::OUT_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  // Configuration registers
  logic [imm_pkg::CFG_DATA_W-1:0] rows_a, inner_dim, cols_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= imm_pkg::DIM_RESET;
      inner_dim <= imm_pkg::DIM_RESET;
      cols_b    <= imm_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        imm_pkg::CFG_ROWS_A:    rows_a    <= cfg_data;
        imm_pkg::CFG_INNER_DIM: inner_dim <= cfg_data;
        imm_pkg::CFG_COLS_B:    cols_b    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Dimensions saturated to the store size
  logic [LW-1:0] rows_lim, cols_lim, n_lim;

  assign rows_lim = (LW'(rows_a) > LW'(MAX_DIM)) ? LW'(MAX_DIM) : LW'(rows_a);
  assign cols_lim = (LW'(cols_b) > LW'(MAX_DIM)) ? LW'(MAX_DIM) : LW'(cols_b);
  assign n_lim    = (LW'(inner_dim) > LW'(MAX_DIM)) ? LW'(MAX_DIM) : LW'(inner_dim);

  // Request decode
  logic req_fire, in_store, read_err;
  logic wr_a, wr_b, rd_start;
  logic signed [XW-1:0] elem_ext;
  logic [AW-1:0] wr_addr;

  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign in_store  = (LW'(req.row_index) < LW'(MAX_DIM)) &&
                     (LW'(req.col_index) < LW'(MAX_DIM));
  assign read_err  = (LW'(req.row_index) >= rows_lim) ||
                     (LW'(req.col_index) >= cols_lim);
  assign elem_ext  = XW'(req.element_value);
  assign wr_addr   = AW'(int'(req.row_index) * MAX_DIM + int'(req.col_index));

  always_comb begin
    wr_a     = 1'b0;
    wr_b     = 1'b0;
    rd_start = 1'b0;
    unique case (req.op)
      imm_pkg::OP_LOAD_A: wr_a = req_fire && in_store;
      imm_pkg::OP_LOAD_B: wr_b = req_fire && in_store;
      imm_pkg::OP_READ:   rd_start = req_fire;
      default: ;
    endcase
  end

  // Latched read request
  logic [3:0]    row_q, col_q;
  logic          err_q;
  logic [LW-1:0] k;

  // Issue one A/B element pair per cycle while k < n
  logic          issue;
  logic [AW-1:0] addr_a, addr_b;

  assign issue  = (state == S_RUN) && (k < n_lim);
  assign addr_a = AW'(int'(row_q) * MAX_DIM + int'(k));
  assign addr_b = AW'(int'(k) * MAX_DIM + int'(col_q));

  // Element memories: one write port, one registered read port each
  logic signed [EW-1:0] a_mem [DEPTH];
  logic signed [EW-1:0] b_mem [DEPTH];
  logic signed [EW-1:0] a_rd, b_rd;

  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[wr_addr] <= elem_ext[EW-1:0];
    end
    if (issue) begin
      a_rd <= a_mem[addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      b_mem[wr_addr] <= elem_ext[EW-1:0];
    end
    if (issue) begin
      b_rd <= b_mem[addr_b];
    end
  end

  // Multiply and accumulate stages
  logic                        rd_v, mul_v;
  logic signed [2*EW-1:0]      prod;
  logic signed [PW-1:0]        prod_ext;
  logic [imm_pkg::OUT_W-1:0]   acc;

  assign prod_ext = PW'(prod);

  always_ff @(posedge clk) begin
    if (rd_v) begin
      prod <= a_rd * b_rd;
    end
    if (rd_start) begin
      acc <= '0;
    end else if (mul_v) begin
      acc <= acc + prod_ext[imm_pkg::OUT_W-1:0];
    end
    if (rd_start) begin
      row_q <= req.row_index;
      col_q <= req.col_index;
      err_q <= read_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
      k     <= '0;
    end else begin
      rd_v  <= issue;
      mul_v <= rd_v;
      if (rd_start) begin
        k <= '0;
      end else if (issue) begin
        k <= k + 1'b1;
      end
    end
  end

  // Control sequence
  logic rsp_free;

  assign rsp_free = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (rd_start) begin
          state_next = read_err ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        if (!issue && !rd_v && !mul_v) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && rsp_free) begin
      rsp.product_value <= err_q ? '0 : signed'(acc);
      rsp.index_error   <= err_q;
    end
  end

  // Checks
  a_no_write_during_run: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !(wr_a || wr_b))
    else $error("element write while a read is in progress");

  a_drained_at_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (!rd_v && !mul_v))
    else $error("result taken before the pipeline drained");

  a_k_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (k <= n_lim))
    else $error("inner index ran past the inner dimension");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.index_error) |-> (rsp.product_value == '0))
    else $error("index error response with nonzero value");

  a_done_loads_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && rsp_free) |=> (rsp_valid && state == S_IDLE))
    else $error("finished read did not reach the output register");

endmodule
